[rtl/least_loaded_node_selector_unit_defines.svh]
// ============================================================================
// least_loaded_node_selector_unit_defines.svh
// Assertion macros used by the node selector back end (llns_back).
// ============================================================================
`ifndef LEAST_LOADED_NODE_SELECTOR_UNIT_DEFINES_SVH
`define LEAST_LOADED_NODE_SELECTOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define LLNS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// condition that must never be seen out of reset
`define LLNS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define LLNS_ASSERT(lbl, prop, msg)
`define LLNS_NEVER(lbl, cond, msg)
`endif

`endif

[rtl/llns_pkg.sv]
// ============================================================================
// llns_pkg
// Types and constants of the least-loaded node selector.
// ============================================================================
package llns_pkg;

    localparam int LLNS_MAX_NODES = 16;
    localparam int ID_W    = 4;
    localparam int SCORE_W = 14;
    localparam int KEY_W   = 64;
    localparam int RATIO_W = 10;

    // action codes
    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_RECORD = 2'd2;
    localparam logic [1:0] ACT_GET    = 2'd3;

    // status codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_CHOSEN   = 2'd1;
    localparam logic [1:0] ST_NO_NODES = 2'd2;
    localparam logic [1:0] ST_NO_METRIC = 2'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic [ID_W-1:0]    node_id;
        logic signed [11:0] util;
        logic signed [31:0] used_mb;
        logic signed [31:0] total_mb;
        logic [KEY_W-1:0]   key_hash;
    } t_cmd;

    typedef struct packed {
        logic [1:0]      status;
        logic [ID_W-1:0] chosen_node;
    } t_res;

    // classified job: clamped operands, ready for the back end
    typedef struct packed {
        logic [1:0]       action;
        logic [ID_W-1:0]  node_id;
        logic [10:0]      util_c;
        logic [30:0]      used_c;
        logic [30:0]      total_c;
        logic [KEY_W-1:0] key_hash;
    } t_job;

endpackage

[rtl/llns_front.sv]
// ============================================================================
// llns_front
// Accepts commands, clamps the metric operands and queues up to two jobs.
// ============================================================================
module llns_front
    import llns_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_cmd i_cmd,
    output logic busy,
    output logic o_job_valid,
    output t_job o_job,
    input  logic i_job_pop
);

    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_qcnt;
    t_job       job_in;
    logic       push;

    // clamp util to 0..1024 and the memory figures to non-negative
    always_comb begin
        job_in.action   = i_cmd.action;
        job_in.node_id  = i_cmd.node_id;
        job_in.key_hash = i_cmd.key_hash;
        if (i_cmd.util[11]) begin
            job_in.util_c = 11'd0;
        end else if (i_cmd.util > 12'sd1024) begin
            job_in.util_c = 11'd1024;
        end else begin
            job_in.util_c = i_cmd.util[10:0];
        end
        job_in.used_c  = i_cmd.used_mb[31]  ? 31'd0 : i_cmd.used_mb[30:0];
        job_in.total_c = i_cmd.total_mb[31] ? 31'd0 : i_cmd.total_mb[30:0];
    end

    assign busy        = (r_qcnt == 2'd2);
    assign push        = start && !busy;
    assign o_job_valid = (r_qcnt != 2'd0);
    assign o_job       = r_q[r_rp];

    // two-entry job queue
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= job_in;
        end
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_qcnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_job_pop) begin
                r_rp <= ~r_rp;
            end
            r_qcnt <= r_qcnt + {1'b0, push} - {1'b0, i_job_pop};
        end
    end

endmodule

[rtl/llns_back.sv]
// ============================================================================
// llns_back
// Executes jobs: membership list, metric scoring and least-loaded pick.
// ============================================================================
`include "least_loaded_node_selector_unit_defines.svh"

module llns_back
    import llns_pkg::*;
#(
    parameter int MAX_NODES = LLNS_MAX_NODES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_valid,
    input  t_job i_job,
    output logic o_job_pop,
    output logic o_strobe,
    output t_res o_res
);

    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RM   = 3'd1;
    localparam logic [2:0] S_G1   = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_G2   = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;

    logic [2:0]         r_state;
    logic [15:0]        r_member;
    logic [15:0]        r_mval;
    logic [SCORE_W-1:0] r_score [16];
    logic [ID_W-1:0]    r_order [MAX_NODES];
    logic [ID_W-1:0]    r_rd;
    logic               r_pv;
    logic [CW-1:0]      r_cnt, r_i, r_w, r_ties, r_rem, r_seen;
    logic [SCORE_W-1:0] r_best;
    t_job               r_job;
    logic [KEY_W-1:0]   r_kh;
    logic [3:0]         r_mcnt;
    logic [31:0]        r_drem;
    logic [RATIO_W-1:0] r_q;
    logic [3:0]         r_dcnt;
    logic               r_strobe;
    t_res               r_res;

    logic               mem_we;
    logic [IW-1:0]      mem_wa;
    logic [ID_W-1:0]    mem_wd;
    logic               walk_more;
    logic [SCORE_W-1:0] cur_score;
    logic               cur_valid;
    logic [CW-1:0]      rem_next;
    logic [CW:0]        rem_t;
    logic [31:0]        div_t;
    logic [31:0]        div_next;
    logic [SCORE_W-1:0] rec_score_div;
    logic [SCORE_W-1:0] rec_score_full;

    assign walk_more = (r_i < r_cnt);
    assign cur_score = r_score[r_rd];
    assign cur_valid = r_mval[r_rd];
    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;
    assign o_strobe  = r_strobe;
    assign o_res     = r_res;

    // four remainder steps of key_hash mod ties per cycle
    always_comb begin
        rem_t    = '0;
        rem_next = r_rem;
        for (int k = 0; k < 4; k++) begin
            rem_t = {rem_next, r_kh[KEY_W-1-k]};
            if (rem_t >= {1'b0, r_ties}) begin
                rem_t = rem_t - {1'b0, r_ties};
            end
            rem_next = rem_t[CW-1:0];
        end
    end

    // one restoring division step of used*1024/total
    always_comb begin
        div_t    = {r_drem[30:0], 1'b0};
        div_next = div_t;
        if (div_t >= {1'b0, r_job.total_c}) begin
            div_next = div_t - {1'b0, r_job.total_c};
        end
    end

    // score = 7*util + 3*ratio
    assign rec_score_div  = SCORE_W'(r_job.util_c) * SCORE_W'(7)
                          + SCORE_W'({r_q, (div_t >= {1'b0, r_job.total_c})}) * SCORE_W'(3);
    assign rec_score_full = SCORE_W'(i_job.util_c) * SCORE_W'(7)
                          + ((i_job.total_c == 31'd0) ? SCORE_W'(0) :
                             SCORE_W'(3 * 1024));

    // write port of the order list: append on add, compaction on remove
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_w[IW-1:0];
        mem_wd = r_rd;
        if (r_state == S_IDLE && o_job_pop && i_job.action == ACT_ADD) begin
            mem_we = !r_member[i_job.node_id] && (r_cnt < CW'(MAX_NODES));
            mem_wa = r_cnt[IW-1:0];
            mem_wd = i_job.node_id;
        end else if (r_state == S_RM && r_pv && r_rd != r_job.node_id) begin
            mem_we = 1'b1;
        end
    end

    // order list memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_order[mem_wa] <= mem_wd;
        end
        r_rd <= r_order[r_i[IW-1:0]];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_member <= '0;
            r_mval   <= '0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
            r_pv     <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_res    <= '{status: ST_DONE, chosen_node: '0};
            // shared walk over the order list
            r_pv <= walk_more;
            if (walk_more) begin
                r_i <= r_i + CW'(1);
            end
            unique case (r_state)
                S_IDLE: begin
                    r_i  <= '0;
                    r_w  <= '0;
                    r_pv <= 1'b0;
                    if (i_job_valid) begin
                        r_job <= i_job;
                        r_kh  <= i_job.key_hash;
                        unique case (i_job.action)
                            ACT_ADD: begin
                                if (!r_member[i_job.node_id] && r_cnt < CW'(MAX_NODES)) begin
                                    r_cnt <= r_cnt + CW'(1);
                                    r_member[i_job.node_id] <= 1'b1;
                                end
                                r_strobe <= 1'b1;
                            end
                            ACT_REMOVE: begin
                                r_mval[i_job.node_id] <= 1'b0;
                                if (r_member[i_job.node_id]) begin
                                    r_state <= S_RM;
                                end else begin
                                    r_strobe <= 1'b1;
                                end
                            end
                            ACT_RECORD: begin
                                if (i_job.total_c == 31'd0
                                    || i_job.used_c >= i_job.total_c) begin
                                    r_score[i_job.node_id] <= rec_score_full;
                                    r_mval[i_job.node_id]  <= 1'b1;
                                    r_strobe <= 1'b1;
                                end else begin
                                    r_drem  <= {1'b0, i_job.used_c};
                                    r_q     <= '0;
                                    r_dcnt  <= 4'd0;
                                    r_state <= S_DIV;
                                end
                            end
                            ACT_GET: begin
                                if (r_cnt == '0) begin
                                    r_strobe <= 1'b1;
                                    r_res    <= '{status: ST_NO_NODES, chosen_node: '0};
                                end else begin
                                    r_ties  <= '0;
                                    r_state <= S_G1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_RM: begin
                    if (r_pv && r_rd != r_job.node_id) begin
                        r_w <= r_w + CW'(1);
                    end
                    if (!walk_more && !r_pv) begin
                        r_cnt    <= r_w;
                        r_member[r_job.node_id] <= 1'b0;
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_G1: begin
                    if (r_pv && cur_valid) begin
                        if (r_ties == '0 || cur_score < r_best) begin
                            r_best <= cur_score;
                            r_ties <= CW'(1);
                        end else if (cur_score == r_best) begin
                            r_ties <= r_ties + CW'(1);
                        end
                    end
                    if (!walk_more && !r_pv) begin
                        if (r_ties == '0) begin
                            r_strobe <= 1'b1;
                            r_res    <= '{status: ST_NO_METRIC, chosen_node: '0};
                            r_state  <= S_IDLE;
                        end else begin
                            r_rem   <= '0;
                            r_mcnt  <= 4'd0;
                            r_state <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    r_i    <= '0;
                    r_pv   <= 1'b0;
                    r_rem  <= rem_next;
                    r_kh   <= r_kh << 4;
                    r_mcnt <= r_mcnt + 4'd1;
                    r_seen <= '0;
                    if (r_mcnt == 4'd15) begin
                        r_state <= S_G2;
                    end
                end
                S_G2: begin
                    if (r_pv && cur_valid && cur_score == r_best) begin
                        r_seen <= r_seen + CW'(1);
                        if (r_seen == r_rem) begin
                            r_strobe <= 1'b1;
                            r_res    <= '{status: ST_CHOSEN, chosen_node: r_rd};
                            r_state  <= S_IDLE;
                        end
                    end
                end
                S_DIV: begin
                    r_drem <= div_next;
                    r_q    <= {r_q[RATIO_W-2:0], (div_t >= {1'b0, r_job.total_c})};
                    r_dcnt <= r_dcnt + 4'd1;
                    if (r_dcnt == 4'(RATIO_W - 1)) begin
                        r_score[r_job.node_id] <= rec_score_div;
                        r_mval[r_job.node_id]  <= 1'b1;
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
    `LLNS_ASSERT(a_cnt_bound, r_cnt <= CW'(MAX_NODES), "member count above capacity")
    `LLNS_NEVER(a_mod_rem, (r_state == S_MOD) && (r_rem >= r_ties), "tie remainder out of range")
    `LLNS_NEVER(a_div_rem, (r_state == S_DIV) && (r_drem >= {1'b0, r_job.total_c}),
        "division remainder not below divisor")
    `LLNS_NEVER(a_g2_ties, (r_state == S_G2) && (r_ties == '0), "pick walk without ties")

endmodule

[rtl/least_loaded_node_selector_unit.sv]
// ============================================================================
// least_loaded_node_selector_unit
// Node membership list with least-loaded selection and hashed tie break.
// ============================================================================
// channel   ports                          handshake
// command   i_cmd (t_cmd)                  taken when start && !busy
// result    o_res (t_res)                  valid one cycle with o_strobe
//
// Commands queue two deep ahead of a sequencer; busy rises when the queue is full.
// Add, and record of a full or zero ratio, are done in the idle state; record
// with a quotient runs a 10-step divider, remove of a member one walk of the
// order list, and get two walks of the order list through its single read
// port with the key_hash remainder between them at four bits per cycle.
// Reset is synchronous, active low, and empties the list and metrics.
// Results are not back-pressured.
// ============================================================================
module least_loaded_node_selector_unit
    import llns_pkg::*;
#(
    parameter int MAX_NODES = LLNS_MAX_NODES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_cmd i_cmd,
    output logic busy,
    output logic o_strobe,
    output t_res o_res
);

    logic job_valid;
    logic job_pop;
    t_job job;

    llns_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_cmd       (i_cmd),
        .busy        (busy),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    llns_back #(
        .MAX_NODES (MAX_NODES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .o_strobe    (o_strobe),
        .o_res       (o_res)
    );

endmodule
